>>> src/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_W        = $clog2(OPERAND_BITS + 1);
    localparam int EXT_W        = OPERAND_BITS + 2;   // holds 2*acc + x < 3*m

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [CNT_W-1:0]        t_count;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } t_state;

    // request into the shared multiply-reduce unit
    typedef struct packed {
        logic     start;
        t_operand x;
        t_operand y;
        t_operand m;
    } t_mm_req;

    // status back from the unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

>>> src/mexp_mulmod.sv
// Iterative shift-and-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod import mexp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mm_req  i_req,
    output t_mm_stat o_stat,
    output t_operand o_product
);

    t_operand r_acc, r_x, r_y, r_m;
    t_operand n_acc;
    t_count   r_cnt;
    logic     r_busy, r_done;

    logic [EXT_W-1:0] w_sum, w_m1, w_m2, w_d1, w_d2;

    // t = 2*acc + bit*x, then subtract m or 2m to bring it back below m
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + (r_y[OPERAND_BITS-1] ? {2'b00, r_x} : '0);
        w_m1  = {2'b00, r_m};
        w_m2  = {1'b0, r_m, 1'b0};
        w_d1  = w_sum - w_m1;
        w_d2  = w_sum - w_m2;
        if (w_sum >= w_m2) begin
            n_acc = w_d2[OPERAND_BITS-1:0];
        end else if (w_sum >= w_m1) begin
            n_acc = w_d1[OPERAND_BITS-1:0];
        end else begin
            n_acc = w_sum[OPERAND_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= t_count'(OPERAND_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - t_count'(1);
                if (r_cnt == t_count'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_x   <= i_req.x;
            r_y   <= i_req.y;
            r_m   <= i_req.m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[OPERAND_BITS-2:0], 1'b0};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

>>> src/modular_exponentiation.sv
// Each transaction with a nonzero modulus takes 1 + N + popcount(exponent) products,
//   N = OPERAND_BITS; every product runs on the one bit-serial multiply-reduce unit.
// Flow: one transaction at a time; o_stall
//   stays high from acceptance until the result transaction has been taken.
// Reset: synchronous, active low; returns the sequencer and the multiplier to idle.
// Zero modulus goes straight to the done state and returns 0 without using the multiplier.
module modular_exponentiation import mexp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input channel
    input  logic     i_valid,
    output logic     o_stall,
    input  t_operand i_base,
    input  t_operand i_exponent,
    input  t_operand i_modulus,
    // output channel
    output logic     o_valid,
    input  logic     i_stall,
    output t_operand o_power_mod
);

    t_state   r_state, n_state;

    // working registers: exponent shifts left so its MSB is the current bit
    t_operand r_e, n_e;
    t_operand r_base, n_base;     // base reduced mod m
    t_operand r_m, n_m;
    t_operand r_r, n_r;           // partial result
    t_count   r_k, n_k;           // exponent bits still to process

    t_mm_req  w_req;
    t_mm_stat w_stat;
    t_operand w_prod;

    logic     w_in_acc, w_out_acc;
    t_operand w_one;

    // shared multiply-reduce unit: every product goes through it
    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_stat    (w_stat),
        .o_product (w_prod)
    );

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    // 1 mod m: zero when the modulus is one
    assign w_one     = (i_modulus == t_operand'(1)) ? '0 : t_operand'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_modulus == '0) ? ST_DONE : ST_RED_BASE;
                end
            end
            ST_RED_BASE: begin
                if (w_stat.done) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (w_stat.done) begin
                    if (r_e[OPERAND_BITS-1]) begin
                        n_state = ST_MULT;
                    end else if (r_k == t_count'(1)) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_MULT: begin
                if (w_stat.done) begin
                    n_state = (r_k == t_count'(1)) ? ST_DONE : ST_SQUARE;
                end
            end
            ST_DONE: begin
                if (w_out_acc) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier requests
    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        o_valid     = (r_state == ST_DONE);
        o_power_mod = r_r;
        w_req.start = 1'b0;
        w_req.x     = w_prod;
        w_req.y     = w_prod;
        w_req.m     = r_m;
        unique case (r_state)
            ST_IDLE: begin
                // base mod m, formed as (1 mod m) * base
                w_req.start = w_in_acc && (i_modulus != '0);
                w_req.x     = w_one;
                w_req.y     = i_base;
                w_req.m     = i_modulus;
            end
            ST_RED_BASE: begin
                // first square of the partial result, which is still 1 mod m
                w_req.start = w_stat.done;
                w_req.x     = r_r;
                w_req.y     = r_r;
            end
            ST_SQUARE: begin
                if (r_e[OPERAND_BITS-1]) begin
                    w_req.start = w_stat.done;
                    w_req.y     = r_base;
                end else begin
                    w_req.start = w_stat.done && (r_k != t_count'(1));
                end
            end
            ST_MULT: begin
                w_req.start = w_stat.done && (r_k != t_count'(1));
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // working register updates
    always_comb begin
        n_e    = r_e;
        n_base = r_base;
        n_m    = r_m;
        n_r    = r_r;
        n_k    = r_k;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_e = i_exponent;
                    n_m = i_modulus;
                    n_r = (i_modulus == '0) ? '0 : w_one;
                    n_k = t_count'(OPERAND_BITS);
                end
            end
            ST_RED_BASE: begin
                if (w_stat.done) begin
                    n_base = w_prod;
                end
            end
            ST_SQUARE: begin
                if (w_stat.done) begin
                    n_r = w_prod;
                    if (!r_e[OPERAND_BITS-1]) begin
                        n_e = {r_e[OPERAND_BITS-2:0], 1'b0};
                        n_k = r_k - t_count'(1);
                    end
                end
            end
            ST_MULT: begin
                if (w_stat.done) begin
                    n_r = w_prod;
                    n_e = {r_e[OPERAND_BITS-2:0], 1'b0};
                    n_k = r_k - t_count'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_base <= n_base;
        r_m    <= n_m;
        r_r    <= n_r;
    end

    // the sequencer never restarts the multiplier while it is still iterating
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_stat.busy)
        else $error("multiplier restarted while busy");

    // a finished product only shows up while a product is being waited for
    a_done_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_RED_BASE || r_state == ST_SQUARE ||
                         r_state == ST_MULT))
        else $error("multiplier done outside a compute state");

    // every result with a nonzero modulus is fully reduced
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_m != '0) |-> (o_power_mod < r_m))
        else $error("result not reduced below modulus");

    // an accepted transaction leaves the input side stalled straight after its acceptance
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_stall)
        else $error("input not stalled after acceptance");

endmodule

>>> dv/mexp_checker.sv
// Checker: watches both channels, predicts each power_mod and compares in order.
module mexp_checker import mexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_operand    i_base,
    input  t_operand    i_exponent,
    input  t_operand    i_modulus,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_operand    i_power_mod,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_operand base;
        t_operand exponent;
        t_operand modulus;
        t_operand power_mod;
    } t_expected_power;

    t_expected_power expected_powers[$];

    // (x * y) mod m, shift-and-add from the top bit of y; x, y < m
    function automatic logic [63:0] mulmod_shift_add(logic [63:0] x, logic [63:0] y,
                                                     logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        for (int k = OPERAND_BITS - 1; k >= 0; k--) begin
            acc = acc + acc;
            if (acc >= m) acc = acc - m;
            if (y[k]) begin
                acc = acc + x;
                if (acc >= m) acc = acc - m;
            end
        end
        return acc;
    endfunction

    function automatic t_operand predict_power_mod(t_operand b_in, t_operand e_in,
                                                   t_operand m_in);
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] r;
        m = 64'(m_in);
        if (m == 0) return '0;    // zero modulus gives zero
        b = 64'(b_in) % m;
        r = 64'd1 % m;
        for (int k = OPERAND_BITS - 1; k >= 0; k--) begin
            r = mulmod_shift_add(r, r, m);
            if (e_in[k]) r = mulmod_shift_add(r, b, m);
        end
        return r[OPERAND_BITS-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_expected_power exp_item;
        t_expected_power new_item;
        if (!i_rst_n) begin
            expected_powers.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
        end else begin
            // result first: it belongs to an older transaction than any input this cycle
            if (i_out_valid && !i_out_stall) begin
                if (expected_powers.size() == 0) begin
                    $error("unexpected result transaction: power_mod %0d", i_power_mod);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_item = expected_powers.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_power_mod !== exp_item.power_mod) begin
                        $error({"power_mod mismatch: expected %0d, actual %0d ",
                                "(base %0d exponent %0d modulus %0d)"},
                               exp_item.power_mod, i_power_mod,
                               exp_item.base, exp_item.exponent, exp_item.modulus);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                new_item.base      = i_base;
                new_item.exponent  = i_exponent;
                new_item.modulus   = i_modulus;
                new_item.power_mod = predict_power_mod(i_base, i_exponent, i_modulus);
                expected_powers = {expected_powers, new_item};
            end
            o_pending <= expected_powers.size();
        end
    end

endmodule

>>> dv/tb_modular_exponentiation.sv
// Testbench top: stimulus, idle/stall shaping and verdict for modular_exponentiation.
module tb_modular_exponentiation;
    import mexp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       CLK_HALF       = 6;        // 12 ns period
    localparam int       RESET_CYCLES   = 7;
    localparam int       HOLD_CYCLES    = 3000;     // long output hold-off, > one item latency
    localparam int       DRAIN_CYCLES   = 2100;     // longest latency plus margin
    localparam longint   TIMEOUT_CYCLES = 3_000_000;
    localparam int       NUM_PHASES     = 4;
    localparam t_operand OP_MAX         = '1;

    // per phase: sender idle %, receiver stall %, random transactions
    localparam int PHASE_IDLE[NUM_PHASES]  = '{0, 80, 0, 34};
    localparam int PHASE_STALL[NUM_PHASES] = '{0, 0, 80, 34};
    localparam int PHASE_ITEMS[NUM_PHASES] = '{70, 70, 65, 65};

    // all inputs known from time zero
    logic     i_clk      = 1'b0;
    logic     i_rst_n    = 1'b0;
    logic     i_valid    = 1'b0;
    logic     i_stall    = 1'b0;
    t_operand i_base     = '0;
    t_operand i_exponent = '0;
    t_operand i_modulus  = '0;
    logic     o_stall;
    logic     o_valid;
    t_operand o_power_mod;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // knobs shared with the receiver process; only the main process writes them
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;

    modular_exponentiation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_power_mod (o_power_mod)
    );

    mexp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_base       (i_base),
        .i_exponent   (i_exponent),
        .i_modulus    (i_modulus),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_power_mod  (o_power_mod),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Receiver: random stall per cycle at stall_pct. A new hold request makes it
    // keep i_stall high for HOLD_CYCLES, counted here, while the sender keeps
    // offering; the block then holds its result and stalls its own input.
    initial begin : receiver
        int hold_ack;
        hold_ack = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one transaction: optional idle gap first, then hold valid and the
    // payload steady until the block takes it. Valid stays high on return so
    // back-to-back transactions never drop it within a step.
    task automatic offer_operands(input t_operand b, input t_operand e, input t_operand m);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_base     <= b;
        i_exponent <= e;
        i_modulus  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_operand b;
        t_operand e;
        t_operand m;
        int       sel;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners, no idling.
        offer_operands('0, '0, OP_MAX);                    // 0^0 with large modulus -> 1
        offer_operands('0, '0, 31'd1);                     // 0^0 modulo one -> 0
        offer_operands('0, '0, '0);                        // zero modulus
        offer_operands(OP_MAX, OP_MAX, '0);                // zero modulus, all ones elsewhere
        offer_operands(OP_MAX, OP_MAX, OP_MAX);            // base reduces to zero
        offer_operands(OP_MAX, OP_MAX, 31'd1);             // modulus one
        offer_operands(31'd123, 31'd456, 31'd1);           // modulus one
        offer_operands(OP_MAX - 31'd1, 31'd2, OP_MAX);     // largest residue squared
        offer_operands('0, 31'd5, 31'd97);                 // zero base, nonzero exponent
        offer_operands(31'd1, OP_MAX, OP_MAX - 31'd1);     // unit base, max exponent
        offer_operands(31'd2, 31'd30, OP_MAX);
        offer_operands(31'd2, 31'd31, OP_MAX);             // wraps to one
        offer_operands(31'd5, 31'd1, 31'd3);               // base above modulus
        offer_operands(OP_MAX, 31'd1, 31'd2);
        offer_operands(31'd3, OP_MAX, 31'd2);
        offer_operands(31'd7, '0, 31'd13);                 // zero exponent, nonzero base
        offer_operands(31'd10, 31'd1, 31'd10);             // base equals modulus
        offer_operands(31'd2, 31'h4000_0000, 31'd1000003); // only the top exponent bit
        offer_operands(31'h5555_5555, 31'h2AAA_AAAA, 31'h7FFF_FFED);
        offer_operands(31'h2AAA_AAAA, 31'h5555_5555, 31'h4000_0000); // power-of-two modulus
        offer_operands(OP_MAX, 31'd65537, 31'd2147483629);

        // Random phases with different idle/stall mixes.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_pct  = PHASE_IDLE[ph];
            stall_pct = PHASE_STALL[ph];
            if (ph == 0) hold_req = hold_req + 1;   // back-pressure burst early on
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                // modulus: mostly full range, some tiny, some near the top, a few zero
                sel = $urandom_range(99);
                if (sel < 5)
                    m = '0;
                else if (sel < 20)
                    m = t_operand'($urandom_range(255, 1));
                else if (sel < 30)
                    m = OP_MAX - t_operand'($urandom_range(15));
                else begin
                    m = t_operand'($urandom);
                    if (m == '0) m = 31'd1;
                end
                // base: full range, tiny, or at or just above the modulus
                sel = $urandom_range(99);
                if (sel < 70)
                    b = t_operand'($urandom);
                else if (sel < 85)
                    b = t_operand'($urandom_range(3));
                else
                    b = m + t_operand'($urandom_range(7));
                // exponent: full range, tiny, or all ones
                sel = $urandom_range(99);
                if (sel < 75)
                    e = t_operand'($urandom);
                else if (sel < 90)
                    e = t_operand'($urandom_range(7));
                else
                    e = OP_MAX;
                offer_operands(b, e, m);
            end
        end
        i_valid <= 1'b0;

        // Let every result come back, then watch for strays over one more latency.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d results checked, directed corners then four idle/stall mixes",
                 checked);
        $display("summary: one %0d-cycle output hold-off backed up the input side", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("watchdog expired with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule
